// ===== sv/ptts_pkg.sv =====
`default_nettype none
package ptts_pkg;
  typedef enum logic [2:0] {
    FN_ADD = 3'd0, FN_UPDATE = 3'd1, FN_REMOVE = 3'd2, FN_IRQ = 3'd3, FN_POLL = 3'd4
  } func_t;

  localparam logic [1:0] PRIO_NORMAL = 2'd0;
  localparam logic [1:0] PRIO_HIGH = 2'd1;
  localparam logic [1:0] PRIO_INTERRUPT = 2'd2;
  localparam logic [1:0] PRIO_BACKGROUND = 2'd3;
  localparam logic [15:0] DUE_MARK = 16'd60000;
  localparam logic [15:0] ONE_SHOT = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  handle;
    logic [15:0] period_ms;
    logic [15:0] start_delay;
    logic [1:0]  priority_req;
    logic [15:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  result_handle;
    logic        is_fire;
    logic [15:0] next_due;
    logic        last;
  } out_item_t;

  // Classified command passed from front to back.
  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  handle;
    logic [15:0] period_ms;
    logic [15:0] delay;
    logic [1:0]  priority_req;
    logic [15:0] now_ms;
  } cmd_t;
endpackage
`default_nettype wire

// ===== sv/ptts_if.sv =====
`default_nettype none
interface ptts_in_if import ptts_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ptts_out_if import ptts_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/priority_timer_task_scheduler.sv =====
`default_nettype none
// Timed task scheduler with priorities.
// Input channel (in_): one item per command: add, update, remove, mark
//   interrupt, or poll at now_ms. Result channel (out_): one or more items
//   per command; the final one carries last = 1, a poll's also next_due.
// Items enter a two-entry queue, so the source can run ahead while the back
//   end executes the previous command.
// The back end runs one command at a time and takes the next only once it is
//   idle again and its output register is empty. A poll walks every slot once,
//   one slot per cycle while no fire waits on the output register, from a
//   rotating start, then selects the normal or background task to run.
// Each fired result is held back until the next one is known, so the final
//   one can carry next_due and last; earlier ones go out as the poll runs.
// If the receiver stalls, the walk pauses at a firing slot while a result is
//   held and the output register is full; the queue then fills and in_ready
//   drops.
// Reset (rst_n low, synchronous) empties the table, the queue and the
//   output register and clears the rotation and interrupt flag.
module priority_timer_task_scheduler import ptts_pkg::*; #(
  parameter int TASK_SLOTS = 8
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ptts_in_if.sink    in_ch,
  ptts_out_if.source out_ch
);
  cmd_t q_data;
  logic q_valid, q_ready;

  ptts_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_data(q_data), .q_valid(q_valid), .q_ready(q_ready)
  );

  ptts_back #(.TASK_SLOTS(TASK_SLOTS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_data(q_data), .q_valid(q_valid), .q_ready(q_ready),
    .out_ch(out_ch)
  );
endmodule
`default_nettype wire

// ===== sv/ptts_front.sv =====
`default_nettype none
module ptts_front import ptts_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  ptts_in_if.sink   in_ch,
  output cmd_t      q_data,
  output logic      q_valid,
  input  wire logic q_ready
);
  // Two-entry queue; start delay resolved here.
  cmd_t        mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  cmd_t        cmd;
  logic        push, pop;

  always_comb begin
    cmd.func = in_ch.data.func;
    cmd.handle = in_ch.data.handle;
    cmd.period_ms = in_ch.data.period_ms;
    cmd.delay = (in_ch.data.start_delay == ONE_SHOT) ? in_ch.data.period_ms
                                                     : in_ch.data.start_delay;
    cmd.priority_req = in_ch.data.priority_req;
    cmd.now_ms = in_ch.data.now_ms;
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cmd;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== sv/ptts_back.sv =====
`default_nettype none
module ptts_back import ptts_pkg::*; #(
  parameter int TASK_SLOTS = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cmd_t q_data,
  input  wire logic q_valid,
  output logic      q_ready,
  ptts_out_if.source out_ch
);
  localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam logic [7:0] ROT_MOD = 8'(255 - TASK_SLOTS);

  typedef enum logic [2:0] {ST_IDLE, ST_WALK, ST_EMIT, ST_FINAL, ST_DONE} state_t;

  state_t          state_r;
  cmd_t            cmd_r;
  logic [TASK_SLOTS-1:0] act_r;
  logic [1:0]      prio_r [TASK_SLOTS];
  logic [15:0]     per_r  [TASK_SLOTS];
  logic [15:0]     due_r  [TASK_SLOTS];
  logic [7:0]      rot_r;
  logic [SW-1:0]   srt_r;        // rot_r mod TASK_SLOTS, kept alongside
  logic            irq_r;
  logic [SW-1:0]   idx_r;
  logic [CW-1:0]   step_r;
  logic            nrm_v_r, bg_v_r;
  logic [15:0]     nrm_rem_r, bg_rem_r, next_r, rem_r;
  logic [SW-1:0]   nrm_idx_r, bg_idx_r;
  logic            pend_r;       // a fire result is held back until the next is known
  logic [3:0]      pend_h_r;
  logic            ovalid_r;
  out_item_t       odata_r;

  assign q_ready = (state_r == ST_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data = odata_r;

  logic            hok;
  logic [SW-1:0]   hidx;
  logic            free_found;
  logic [SW-1:0]   free_idx;
  logic [7:0]      rot_inc;
  logic [SW-1:0]   srt_inc;
  logic [15:0]     rem0, remd, nd_fire;
  logic [1:0]      cp;
  logic            cur_due;
  logic            ofree;

  always_comb begin
    hok = (cmd_r.handle != 4'd0) && ({28'd0, cmd_r.handle} <= TASK_SLOTS);
    hidx = SW'(cmd_r.handle - 4'd1);
    free_found = 1'b0;
    free_idx = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!act_r[i]) begin
        free_found = 1'b1;
        free_idx = SW'(i);
      end
    end
    rot_inc = (rot_r + 8'd1 == ROT_MOD) ? 8'd0 : rot_r + 8'd1;
    if (rot_inc == 8'd0) srt_inc = '0;
    else if (srt_r == SW'(TASK_SLOTS - 1)) srt_inc = '0;
    else srt_inc = srt_r + SW'(1);
    rem0 = due_r[idx_r] - cmd_r.now_ms;
    cur_due = rem0 >= DUE_MARK;
    remd = rem0 - 16'd1;
    cp = prio_r[idx_r];
    nd_fire = cmd_r.now_ms + per_r[idx_r] - 16'd1;
  end

  assign ofree = !ovalid_r || out_ch.ready;

  logic [15:0] fin_next;
  logic [SW-1:0] fsel;
  logic        fsel_v;
  always_comb begin
    fsel_v = nrm_v_r || bg_v_r;
    fsel = nrm_v_r ? nrm_idx_r : bg_idx_r;
  end
  assign fin_next = (rem_r < next_r) ? rem_r : next_r;

  always_ff @(posedge clk) begin
    logic      oload;
    out_item_t oload_d;
    oload = 1'b0;
    oload_d = '0;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      act_r <= '0;
      rot_r <= '0;
      srt_r <= '0;
      irq_r <= 1'b0;
      ovalid_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (q_valid && q_ready) begin
            cmd_r <= q_data;
            if (q_data.func == FN_POLL) begin
              rot_r <= rot_inc;
              srt_r <= srt_inc;
              idx_r <= srt_inc;
              step_r <= '0;
              nrm_v_r <= 1'b0; bg_v_r <= 1'b0;
              nrm_rem_r <= ONE_SHOT; bg_rem_r <= ONE_SHOT;
              next_r <= ONE_SHOT; rem_r <= ONE_SHOT;
              pend_r <= 1'b0;
              if (irq_r) begin
                for (int i = 0; i < TASK_SLOTS; i++)
                  if (act_r[i] && prio_r[i] == PRIO_INTERRUPT && per_r[i] != ONE_SHOT)
                    due_r[i] <= q_data.now_ms - 16'd1;
                irq_r <= 1'b0;
              end
              state_r <= ST_WALK;
            end else begin
              state_r <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          // Output register is empty here: the item was only taken with it free.
          oload = 1'b1;
          oload_d = '{result_handle: 4'd0, is_fire: 1'b0, next_due: 16'd0, last: 1'b1};
          case (cmd_r.func)
            FN_ADD: if (free_found) begin
              act_r[free_idx] <= 1'b1;
              prio_r[free_idx] <= cmd_r.priority_req;
              per_r[free_idx] <= cmd_r.period_ms;
              due_r[free_idx] <= cmd_r.now_ms + cmd_r.delay - 16'd1;
              oload_d.result_handle = 4'(free_idx) + 4'd1;
            end
            FN_UPDATE: if (hok && act_r[hidx]) begin
              if (per_r[hidx] != ONE_SHOT) per_r[hidx] <= cmd_r.period_ms;
              due_r[hidx] <= cmd_r.now_ms + cmd_r.delay - 16'd1;
              oload_d.result_handle = cmd_r.handle;
            end
            FN_REMOVE: if (hok) act_r[hidx] <= 1'b0;
            FN_IRQ: irq_r <= 1'b1;
            default: ;
          endcase
          state_r <= ST_IDLE;
        end
        ST_WALK: begin
          // One slot per cycle; a fire waits while an earlier one is held and
          // the output register is still full.
          if (!(act_r[idx_r] && cur_due && (cp == PRIO_HIGH || cp == PRIO_INTERRUPT)
                && pend_r && !ofree)) begin
            if (act_r[idx_r]) begin
              logic [15:0] r;
              r = rem0;
              if (cur_due) begin
                r = remd;
                if (cp == PRIO_HIGH || cp == PRIO_INTERRUPT) begin
                  if (pend_r) begin
                    oload = 1'b1;
                    oload_d = '{result_handle: pend_h_r, is_fire: 1'b1,
                                next_due: 16'd0, last: 1'b0};
                  end
                  pend_h_r <= 4'(idx_r) + 4'd1;
                  pend_r <= 1'b1;
                  if (per_r[idx_r] != ONE_SHOT) begin
                    due_r[idx_r] <= nd_fire;
                    r = per_r[idx_r];
                  end else begin
                    act_r[idx_r] <= 1'b0;
                    r = ONE_SHOT;
                  end
                end else if (cp == PRIO_BACKGROUND) begin
                  if (bg_rem_r != ONE_SHOT) next_r <= 16'd0;
                  if (remd < bg_rem_r) begin
                    bg_rem_r <= remd; bg_idx_r <= idx_r; bg_v_r <= 1'b1;
                  end
                end else begin
                  if (nrm_rem_r != ONE_SHOT) next_r <= 16'd0;
                  if (remd < nrm_rem_r) begin
                    nrm_rem_r <= remd; nrm_idx_r <= idx_r; nrm_v_r <= 1'b1;
                  end
                end
              end
              rem_r <= r;
              if (cp != PRIO_BACKGROUND && r < next_r &&
                  !(cur_due && cp == PRIO_NORMAL && nrm_rem_r != ONE_SHOT))
                next_r <= r;
            end
            idx_r <= (idx_r == SW'(TASK_SLOTS - 1)) ? '0 : idx_r + SW'(1);
            if (step_r == CW'(TASK_SLOTS - 1)) state_r <= ST_EMIT;
            step_r <= step_r + CW'(1);
          end
        end
        ST_EMIT: begin
          if (!fsel_v) begin
            state_r <= ST_FINAL;
          end else if (!pend_r || ofree) begin
            if (pend_r) begin
              oload = 1'b1;
              oload_d = '{result_handle: pend_h_r, is_fire: 1'b1,
                          next_due: 16'd0, last: 1'b0};
            end
            pend_h_r <= 4'(fsel) + 4'd1;
            pend_r <= 1'b1;
            if (per_r[fsel] != ONE_SHOT) begin
              due_r[fsel] <= cmd_r.now_ms + per_r[fsel] - 16'd1;
              rem_r <= per_r[fsel];
            end else begin
              act_r[fsel] <= 1'b0;
              rem_r <= ONE_SHOT;
            end
            state_r <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          // Held fire result, or an empty one, closes the poll.
          if (ofree) begin
            oload = 1'b1;
            oload_d = '{result_handle: pend_r ? pend_h_r : 4'd0, is_fire: pend_r,
                        next_due: fin_next, last: 1'b1};
            pend_r <= 1'b0;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (oload) begin
        ovalid_r <= 1'b1;
        odata_r <= oload_d;
      end else if (out_ch.valid && out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`default_nettype none
module tb_top;
  import ptts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS     = 8;
  localparam int RAND_N    = 185;
  localparam int IDLE_MAX  = 3000;  // cycles with no handshake before giving up
  localparam int LONG_HOLD = 400;   // one long receiver stall to back up the queue

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ptts_in_if  in_ch ();
  ptts_out_if out_ch ();

  priority_timer_task_scheduler #(.TASK_SLOTS(SLOTS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Scheduler shadow: table of tasks plus rotation and interrupt flag
  // ---------------------------------------------------------------------------
  logic        sh_active [SLOTS];
  logic [1:0]  sh_prio   [SLOTS];
  logic [15:0] sh_period [SLOTS];
  logic [15:0] sh_due    [SLOTS];
  logic [7:0]  sh_rot;
  logic        sh_irq;

  out_item_t due_results [$];   // results still owed by the block
  out_item_t step_out [$];      // results of the item just predicted

  int errors, n_in, n_out, n_fire, n_poll, n_full;
  bit long_hold_req;

  function automatic void push_result(logic [3:0] h, logic f, logic [15:0] nd, logic l);
    out_item_t r;
    r.result_handle = h;
    r.is_fire       = f;
    r.next_due      = nd;
    r.last          = l;
    step_out.push_back(r);
  endfunction

  // Fire one slot; returns its candidate remaining time.
  function automatic logic [15:0] run_task(int idx, logic [15:0] now);
    push_result(4'(idx + 1), 1'b1, 16'd0, 1'b0);
    if (sh_period[idx] != ONE_SHOT) begin
      sh_due[idx] = now + sh_period[idx] - 16'd1;
      return sh_period[idx];
    end
    sh_active[idx] = 1'b0;
    return ONE_SHOT;
  endfunction

  function automatic void poll_table(logic [15:0] now);
    int start, idx, run_norm, run_bg;
    logic [15:0] norm_rem, bg_rem, nxt, rem;
    logic [1:0] p;
    run_norm = 0;
    run_bg   = 0;
    norm_rem = ONE_SHOT;
    bg_rem   = ONE_SHOT;
    nxt      = ONE_SHOT;
    rem      = ONE_SHOT;
    sh_rot = 8'((int'(sh_rot) + 1) % (255 - SLOTS));
    if (sh_irq) begin
      for (int i = 0; i < SLOTS; i++)
        if (sh_active[i] && sh_prio[i] == PRIO_INTERRUPT && sh_period[i] != ONE_SHOT)
          sh_due[i] = now - 16'd1;
      sh_irq = 1'b0;
    end
    start = int'(sh_rot) % SLOTS;
    for (int i = 0; i < SLOTS; i++) begin
      idx = (start + i) % SLOTS;
      if (!sh_active[idx]) continue;
      rem = sh_due[idx] - now;
      p = sh_prio[idx];
      if (rem >= DUE_MARK) begin
        rem = rem - 16'd1;
        if (p == PRIO_HIGH || p == PRIO_INTERRUPT) begin
          rem = run_task(idx, now);
        end else if (p == PRIO_BACKGROUND) begin
          if (bg_rem != ONE_SHOT) nxt = 16'd0;   // second due background task
          if (rem < bg_rem) begin
            bg_rem = rem;
            run_bg = idx;
          end
        end else begin
          if (norm_rem != ONE_SHOT) nxt = 16'd0; // second due normal task
          if (rem < norm_rem) begin
            norm_rem = rem;
            run_norm = idx;
          end
        end
      end
      if (p != PRIO_BACKGROUND && rem < nxt) nxt = rem;
    end
    // normal task beats background; last computed rem is folded in either way
    if (norm_rem != ONE_SHOT) rem = run_task(run_norm, now);
    else if (bg_rem != ONE_SHOT) rem = run_task(run_bg, now);
    if (rem < nxt) nxt = rem;
    if (step_out.size() == 0) begin
      push_result(4'd0, 1'b0, nxt, 1'b1);
    end else begin
      step_out[$].next_due = nxt;
      step_out[$].last     = 1'b1;
    end
  endfunction

  function automatic void schedule_step(in_item_t it);
    logic [15:0] dly;
    logic [3:0] h;
    int idx;
    step_out.delete();
    dly = (it.start_delay == ONE_SHOT) ? it.period_ms : it.start_delay;
    h = 4'd0;
    case (func_t'(it.func))
      FN_ADD: begin
        for (int i = 0; i < SLOTS; i++)
          if (!sh_active[i]) begin
            sh_active[i] = 1'b1;
            sh_prio[i]   = it.priority_req;
            sh_period[i] = it.period_ms;
            sh_due[i]    = it.now_ms + dly - 16'd1;
            h = 4'(i + 1);
            break;
          end
        if (h == 4'd0) n_full++;
        push_result(h, 1'b0, 16'd0, 1'b1);
      end
      FN_UPDATE: begin
        if (it.handle != 0 && it.handle <= SLOTS && sh_active[it.handle - 1]) begin
          idx = int'(it.handle) - 1;
          if (sh_period[idx] != ONE_SHOT) sh_period[idx] = it.period_ms;
          sh_due[idx] = it.now_ms + dly - 16'd1;
          h = it.handle;
        end
        push_result(h, 1'b0, 16'd0, 1'b1);
      end
      FN_REMOVE: begin
        if (it.handle != 0 && it.handle <= SLOTS) sh_active[it.handle - 1] = 1'b0;
        push_result(4'd0, 1'b0, 16'd0, 1'b1);
      end
      FN_IRQ: begin
        sh_irq = 1'b1;
        push_result(4'd0, 1'b0, 16'd0, 1'b1);
      end
      FN_POLL: begin
        n_poll++;
        poll_table(it.now_ms);
      end
      default: push_result(4'd0, 1'b0, 16'd0, 1'b1);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef struct {
    in_item_t    it;
    bit          chk;      // typed-in expectation present
    logic [3:0]  exp_h;    // first result handle
    logic [15:0] exp_nd;   // final next_due (polls only)
  } dir_row_t;

  dir_row_t dir_tab [$];

  task automatic add_row(func_t f, int h, int per, int dly, logic [1:0] pri, int now,
                         bit chk = 0, int eh = 0, int end_nd = 0);
    dir_row_t r;
    r.it.func         = f;
    r.it.handle       = 4'(h);
    r.it.period_ms    = 16'(per);
    r.it.start_delay  = 16'(dly);
    r.it.priority_req = pri;
    r.it.now_ms       = 16'(now);
    r.chk    = chk;
    r.exp_h  = 4'(eh);
    r.exp_nd = 16'(end_nd);
    dir_tab.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(in_item_t it, int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    n_in++;
    schedule_step(it);
    foreach (step_out[k]) due_results.push_back(step_out[k]);
  endtask

  // Random field values: mostly small times so tasks come due, a few extremes.
  function automatic logic [15:0] pick_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(0, 40));
    if (r < 80) return ONE_SHOT;
    if (r < 85) return 16'hFFFE;
    return 16'($urandom_range(0, 65535));
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random ready, plus one long hold when requested
  // ---------------------------------------------------------------------------
  initial begin
    int r, n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_ch.ready <= 1'b1;
        n = $urandom_range(1, 20);
      end else begin
        out_ch.ready <= 1'b0;
        n = (r < 95) ? $urandom_range(1, 3) : $urandom_range(15, 50);
      end
      repeat (n) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compares each accepted item with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_out++;
      if (out_ch.data.is_fire) n_fire++;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item: %p", out_ch.data);
      end else begin
        want = due_results.pop_front();
        if (out_ch.data !== want) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch at result %0d: exp h=%0d fire=%0b nd=%0d last=%0b,",
                      " got h=%0d fire=%0b nd=%0d last=%0b"},
                     n_out, want.result_handle, want.is_fire, want.next_due, want.last,
                     out_ch.data.result_handle, out_ch.data.is_fire,
                     out_ch.data.next_due, out_ch.data.last);
        end
      end
    end
  end

  // Watchdog: too long without any handshake ends the run.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
      if (idle >= IDLE_MAX) begin
        $display("timeout: no handshake for %0d cycles, %0d results owed",
                 idle, due_results.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_item_t it;
    logic [15:0] clock_ms;
    int r, wait_cnt;

    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    errors = 0;
    n_in = 0;
    n_out = 0;
    n_fire = 0;
    n_poll = 0;
    n_full = 0;
    long_hold_req = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      sh_active[i] = 1'b0;
      sh_prio[i]   = 2'd0;
      sh_period[i] = 16'd0;
      sh_due[i]    = 16'd0;
    end
    sh_rot = 8'd0;
    sh_irq = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty poll, each priority, bad handles, one-shot, full table
    add_row(FN_POLL,   0,   0,     0,     PRIO_NORMAL,     0,     1, 0, 65535);
    add_row(FN_ADD,    0,   100,   10,    PRIO_NORMAL,     0,     1, 1);
    add_row(FN_ADD,    0,   65535, 5,     PRIO_HIGH,       0,     1, 2);
    add_row(FN_ADD,    0,   50,    1000,  PRIO_INTERRUPT,  0,     1, 3);
    add_row(FN_ADD,    0,   20,    0,     PRIO_BACKGROUND, 0,     1, 4);
    add_row(FN_UPDATE, 0,   7,     7,     PRIO_NORMAL,     0,     1, 0);
    add_row(FN_UPDATE, 8,   7,     7,     PRIO_NORMAL,     0,     1, 0);
    add_row(FN_UPDATE, 1,   200,   65535, PRIO_NORMAL,     0,     1, 1);
    add_row(FN_IRQ,    0,   0,     0,     PRIO_NORMAL,     0,     1, 0);
    add_row(func_t'(3'd5), 0, 0,   0,     PRIO_NORMAL,     0,     1, 0);
    add_row(FN_POLL,   0,   0,     0,     PRIO_NORMAL,     6);
    add_row(FN_POLL,   0,   0,     0,     PRIO_NORMAL,     20);
    add_row(FN_REMOVE, 0,   0,     0,     PRIO_NORMAL,     0,     1, 0);
    add_row(FN_REMOVE, 8,   0,     0,     PRIO_NORMAL,     0,     1, 0);
    add_row(FN_REMOVE, 4,   0,     0,     PRIO_NORMAL,     0,     1, 0);
    for (int i = 0; i < 6; i++)
      add_row(FN_ADD,  0,   65535, 65534, PRIO_BACKGROUND, 65535);
    add_row(FN_ADD,    0,   5,     5,     PRIO_HIGH,       65535, 1, 0);
    add_row(FN_POLL,   0,   0,     0,     PRIO_NORMAL,     65535);
    add_row(FN_UPDATE, 3,   0,     0,     PRIO_NORMAL,     30);
    add_row(FN_POLL,   0,   0,     0,     PRIO_NORMAL,     40);

    foreach (dir_tab[k]) begin
      send_item(dir_tab[k].it, pick_gap());
      if (dir_tab[k].chk && (step_out[0].result_handle !== dir_tab[k].exp_h ||
          (dir_tab[k].it.func == FN_POLL && step_out[$].next_due !== dir_tab[k].exp_nd))) begin
        errors++;
        if (errors <= 10)
          $display("directed row %0d: typed expectation h=%0d nd=%0d disagrees with shadow",
                   k, dir_tab[k].exp_h, dir_tab[k].exp_nd);
      end
    end

    // random: a clock that mostly creeps forward, sometimes jumps or wraps
    clock_ms = 16'd100;
    long_hold_req = 1'b1;
    for (int n = 0; n < RAND_N; n++) begin
      it = '0;
      r = $urandom_range(0, 99);
      if (r < 28)      it.func = FN_ADD;
      else if (r < 43) it.func = FN_UPDATE;
      else if (r < 53) it.func = FN_REMOVE;
      else if (r < 60) it.func = FN_IRQ;
      else             it.func = FN_POLL;
      it.handle       = 4'($urandom_range(0, 9));
      it.period_ms    = pick_time();
      it.start_delay  = pick_time();
      it.priority_req = 2'($urandom_range(0, 3));
      r = $urandom_range(0, 99);
      if (r < 85)      clock_ms = clock_ms + 16'($urandom_range(0, 25));
      else if (r < 95) clock_ms = 16'($urandom_range(0, 65535));
      else             clock_ms = 16'hFFFF - 16'($urandom_range(0, 3));
      it.now_ms = clock_ms;
      send_item(it, pick_gap());
    end
    in_ch.valid <= 1'b0;

    wait_cnt = 0;
    while (due_results.size() != 0 && wait_cnt < 20000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (30) @(posedge clk);

    $display("covered %0d items (%0d polls), %0d results, %0d task firings,",
             n_in, n_poll, n_out, n_fire);
    $display("  %0d full-table adds, one long receiver hold", n_full);
    if (errors == 0 && due_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, due_results.size());
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
sv/ptts_pkg.sv
sv/ptts_if.sv
sv/ptts_front.sv
sv/ptts_back.sv
sv/priority_timer_task_scheduler.sv
sim/tb_top.sv
